// File: hdl/indexed_list_insert_remove_assert.svh
// Assertion macros shared by the list checker
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low
`define ILIR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low
`define ILIR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ilir_pkg.sv
// Package: sizes, request and status codes, cell control types for the indexed list
`timescale 1ns / 1ps
package ilir_pkg;

	// store geometry and field widths
	localparam int DEPTH  = 64;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;
	localparam int REQ_W  = 3;
	localparam int ST_W   = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	// word returned by a failed request
	localparam logic [DATA_W-1:0] FAIL_WORD = '1;

	// what every cell does at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_PUSH   = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// broadcast from the controller to the row of cells
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] word;
		logic [IDX_W-1:0]  raddr;
	} cell_ctl_t;

endpackage

// File: hdl/ilir_cell.sv
// One list cell: holds an entry, shifts with its neighbors, drives the read bus
`timescale 1ns / 1ps
module ilir_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                           clk,
	input  ilir_pkg::cell_ctl_t            ctl,
	input  logic [ilir_pkg::DATA_W-1:0]    left_word,
	input  logic [ilir_pkg::DATA_W-1:0]    right_word,
	output logic [ilir_pkg::DATA_W-1:0]    word,
	output logic [ilir_pkg::DATA_W-1:0]    rd_word
);
	import ilir_pkg::*;

	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [DATA_W-1:0] word_q;
	logic [DATA_W-1:0] word_d;

	// next entry: load, take from left (insert) or right (remove), or keep
	always_comb begin
		word_d = word_q;
		case (ctl.op)
			CELL_PUSH: begin
				if (ctl.cnt == MY_CNT) word_d = ctl.word;
			end
			CELL_INSERT: begin
				if (MY_IDX == ctl.pos)     word_d = ctl.word;
				else if (MY_IDX > ctl.pos) word_d = left_word;
			end
			CELL_REMOVE: begin
				if (MY_IDX >= ctl.pos) word_d = right_word;
			end
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word    = word_q;
	// masked onto the shared read bus when addressed
	assign rd_word = (ctl.raddr == MY_IDX) ? word_q : '0;

endmodule

// File: hdl/ilir_ctrl.sv
// List controller: decode, range and fullness checks, count, limit, result register
`timescale 1ns / 1ps
module ilir_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [ilir_pkg::REQ_W-1:0]         req_type,
	input  logic [ilir_pkg::IDX_W-1:0]         index,
	input  logic [ilir_pkg::DATA_W-1:0]        value,
	input  logic                               cfg_we,
	input  logic [ilir_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic [ilir_pkg::DATA_W-1:0]        bus_word,
	output ilir_pkg::cell_ctl_t                ctl,
	output logic                               done,
	output logic [ilir_pkg::DATA_W-1:0]        rd_value,
	output logic [ilir_pkg::ST_W-1:0]          status,
	output logic [ilir_pkg::CNT_W-1:0]         count
);
	import ilir_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lim_q;
	logic              done_q;
	logic [DATA_W-1:0] rd_value_q;
	logic [ST_W-1:0]   status_q;

	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  count_dec;
	logic [CNT_W-1:0]  idx_ext;
	logic [CNT_W-1:0]  lim_d;
	logic [DATA_W-1:0] rd_d;
	logic [ST_W-1:0]   st_d;
	logic              full;
	logic              pos_ok;
	cell_op_t          op_d;

	assign count_dec = count_q - ONE_C;
	assign idx_ext   = {1'b0, index};
	assign full      = (count_q >= lim_q);
	assign pos_ok    = (idx_ext < count_q);

	// request decode and checks
	always_comb begin
		op_d    = CELL_HOLD;
		count_d = count_q;
		rd_d    = '0;
		st_d    = ST_OK;
		case (req_type)
			REQ_PUSH: begin
				if (full) st_d = ST_FULL;
				else begin
					op_d    = CELL_PUSH;
					count_d = count_q + ONE_C;
				end
			end
			REQ_POP: begin
				if (count_q == '0) st_d = ST_EMPTY;
				else begin
					count_d = count_dec;
					rd_d    = bus_word;
				end
			end
			REQ_INSERT: begin
				if (!pos_ok)   st_d = ST_RANGE;
				else if (full) st_d = ST_FULL;
				else begin
					op_d    = CELL_INSERT;
					count_d = count_q + ONE_C;
				end
			end
			REQ_REMOVE: begin
				if (!pos_ok) st_d = ST_RANGE;
				else begin
					op_d    = CELL_REMOVE;
					count_d = count_dec;
				end
			end
			REQ_READ: begin
				if (!pos_ok) st_d = ST_RANGE;
				else         rd_d = bus_word;
			end
			REQ_CLEAR: begin
				count_d = '0;
			end
			default: begin
				op_d = CELL_HOLD;
			end
		endcase
		if (st_d != ST_OK) rd_d = FAIL_WORD;
	end

	// broadcast to the cells; only a transfer moves them
	always_comb begin
		ctl.op    = accept ? op_d : CELL_HOLD;
		ctl.pos   = index;
		ctl.cnt   = count_q;
		ctl.word  = value;
		ctl.raddr = (req_type == REQ_POP) ? count_dec[IDX_W-1:0] : index;
	end

	// limit in effect, clamped to 1..DEPTH when written
	always_comb begin
		if (cfg_wdata == '0)          lim_d = ONE_C;
		else if (cfg_wdata > DEPTH_C) lim_d = DEPTH_C;
		else                          lim_d = cfg_wdata;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lim_q   <= DEPTH_C;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_d;
			if (cfg_we) lim_q <= lim_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_value_q <= rd_d;
			status_q   <= st_d;
		end
	end

	assign done     = done_q;
	assign rd_value = rd_value_q;
	assign status   = status_q;
	assign count    = count_q;

endmodule

// File: hdl/indexed_list_insert_remove.sv
// Top level: bounded ordered list of signed words held in a row of shifting cells
//
//  channel   handshake            payload
//  request   start && !busy       req_type, index, value
//  result    done (one cycle)     read_value, status, entry_count, is_empty
//  config    cfg_we               cfg_wdata (capacity limit)
//
// One request per cycle. Insert and remove shift all cells from the index
// upward in the same edge; the read bus is an AND-OR over all cells.
// The result shows in the cycle after the transfer, for exactly one cycle.
// busy stays low; the receiver cannot stall the result.
// arst_n clears the count and sets the limit to the store depth; entries
// themselves are not cleared.
`timescale 1ns / 1ps
module indexed_list_insert_remove (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [ilir_pkg::REQ_W-1:0]             req_type,
	input  logic [ilir_pkg::IDX_W-1:0]             index,
	input  logic signed [ilir_pkg::DATA_W-1:0]     value,
	input  logic                                   cfg_we,
	input  logic [ilir_pkg::CNT_W-1:0]             cfg_wdata,
	output logic                                   done,
	output logic signed [ilir_pkg::DATA_W-1:0]     read_value,
	output logic [ilir_pkg::ST_W-1:0]              status,
	output logic [ilir_pkg::CNT_W-1:0]             entry_count,
	output logic                                   is_empty
);
	import ilir_pkg::*;

	cell_ctl_t         ctl;
	logic              accept;
	logic [DATA_W-1:0] bus_word;
	logic [DATA_W-1:0] rd_value;
	logic [DATA_W-1:0] cell_word [DEPTH];
	logic [DATA_W-1:0] cell_rd   [DEPTH];

	// no request ever stalls: busy is tied low
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ilir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.index     (index),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bus_word  (bus_word),
		.ctl       (ctl),
		.done      (done),
		.rd_value  (rd_value),
		.status    (status),
		.count     (entry_count)
	);

	// row of cells, each wired to both neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_w = cell_word[g];
		end else begin : g_mid_r
			assign right_w = cell_word[g+1];
		end

		ilir_cell #(
			.CELL_IDX (g)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[g]),
			.rd_word    (cell_rd[g])
		);
	end

	// read bus: at most one cell is addressed
	always_comb begin
		bus_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			bus_word = bus_word | cell_rd[i];
		end
	end

	assign read_value = rd_value;
	assign is_empty   = (entry_count == '0);

endmodule

// File: hdl/ilir_checker.sv
// Port-level checker for the indexed list, bound to the top level
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_assert.svh"
module ilir_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic [ilir_pkg::REQ_W-1:0]             req_type,
	input  logic                                   done,
	input  logic signed [ilir_pkg::DATA_W-1:0]     read_value,
	input  logic [ilir_pkg::ST_W-1:0]              status,
	input  logic [ilir_pkg::CNT_W-1:0]             entry_count,
	input  logic                                   is_empty
);
	import ilir_pkg::*;

	logic xfer;
	logic clear_xfer;
	logic fail;

	assign xfer       = start && !busy;
	assign clear_xfer = xfer && (req_type == REQ_CLEAR);
	assign fail       = (status != ST_OK);

	// every transfer answers in the next cycle
	`ILIR_ASSERT_NXT(a_xfer_done, xfer, done, "request transfer without a result")
	// no result without a transfer just before
	`ILIR_ASSERT_IMP(a_done_src, done, $past(xfer), "result without a request transfer")
	// failed requests return the fail word
	`ILIR_ASSERT_IMP(a_fail_word, done && fail, read_value == -32'sd1, "failed request value")
	// a clear leaves an empty list
	`ILIR_ASSERT_NXT(a_clear, clear_xfer, entry_count == '0 && is_empty, "clear left entries")

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);
